FILE: rtl/core/lhist_pkg.sv
// Types, constants and helper functions shared by the log2 latency histogram.
package lhist_pkg;

  localparam int unsigned DEF_BUCKETS = 32;
  localparam int unsigned SAMPLE_W    = 64;
  localparam int unsigned DIV_DW      = 64;
  localparam int unsigned DIV_VW      = 64;
  localparam int unsigned RANK_W      = 71;

  // Mode codes of an input item
  localparam logic [1:0] MODE_RECORD   = 2'd0;
  localparam logic [1:0] MODE_SNAPSHOT = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  // Percentile arithmetic
  localparam logic [6:0] PCT_SCALE  = 7'd100;
  localparam logic [6:0] PCT_MEDIAN = 7'd50;
  localparam logic [6:0] PCT_P95    = 7'd95;
  localparam logic [6:0] PCT_P99    = 7'd99;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PRE_WALK,
    ST_WALK,
    ST_DONE
  } lhist_state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] sample_ns;
  } lhist_item_t;

  typedef struct packed {
    logic [63:0] count_out;
    logic [63:0] median_bound;
    logic [63:0] p95_bound;
    logic [63:0] p99_bound;
    logic [63:0] largest_ns;
    logic [63:0] mean_ns;
  } lhist_result_t;

  // Add two counts, stick at all-ones on overflow
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Upper bound of a bucket; the last bucket is open-ended
  function automatic logic [63:0] bound_of(input logic [6:0] idx, input logic [6:0] last);
    logic [63:0] one;
    one = 64'd1;
    if (idx >= last) begin
      return '1;
    end
    return one << idx[5:0];
  endfunction

endpackage

FILE: rtl/core/lhist_div.sv
// Restoring divider, one quotient bit per cycle, used for the snapshot mean.
module lhist_div
  import lhist_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_DW-1:0] dividend_i,
  input  logic [DIV_VW-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_VW-1:0] quotient_o
);

  localparam logic [6:0] LAST_STEP = 7'(DIV_DW - 1);

  logic              run_q;
  logic              done_q;
  logic [6:0]        cnt_q;
  logic [DIV_DW-1:0] quo_q;
  logic [DIV_VW-1:0] rem_q;
  logic [DIV_VW-1:0] dvs_q;
  logic [DIV_VW:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[DIV_DW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == LAST_STEP) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? DIV_VW'(trial - {1'b0, dvs_q}) : trial[DIV_VW-1:0];
      quo_q <= {quo_q[DIV_DW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[DIV_VW-1:0];

endmodule

FILE: rtl/core/log2_latency_histogram_core.sv
// Top level of the log2 latency histogram with percentile snapshot.
//
// Usage: drive item_i and raise start; the item is taken at a clock edge where
// start is high and busy is low. Mode record files a sample in its log2 bucket,
// mode snapshot returns one result, mode clear zeroes all statistics, mode 3 is
// ignored. A result shows on result_o for exactly one cycle with done_o high;
// the receiver cannot stall it, so it must take it in that cycle.
// Sequencing: a record reads its bucket, then writes it back. Clear, the unused
// mode and a snapshot with no samples never raise busy; the empty snapshot
// result appears the cycle after the item is taken. A full snapshot keeps busy
// high until its result shows: it launches the divider, runs 64 bit-serial
// steps for the mean, collects the quotient, sets up, walks the bucket memory
// one entry per cycle through its one read port and registers the result.
// A percentile rank is met when 100 * running count >= count * percentile.
// Reset clears the bucket valid bits, the sample count, sum and peak at once,
// so the block is ready the first cycle after reset.
module log2_latency_histogram_core
  import lhist_pkg::*;
#(
  parameter int unsigned BUCKETS = DEF_BUCKETS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lhist_item_t   item_i,
  output logic          done_o,
  output lhist_result_t result_o
);

  localparam int unsigned IDXW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [6:0]  LAST_B   = 7'(BUCKETS - 1);
  localparam logic [IDXW-1:0] LAST_I = IDXW'(BUCKETS - 1);

  lhist_state_e state_q, state_d;

  logic                accept;
  logic [IDXW-1:0]     rd_addr;
  logic [63:0]         mem_q [BUCKETS];
  logic [BUCKETS-1:0]  vld_q;
  logic [63:0]         rd_data_q;
  logic                rd_vld_q;
  logic [63:0]         bucket_val;
  logic                mem_we;
  logic [63:0]         mem_wdata;

  logic [63:0]         total_q, sum_q, peak_q;
  logic [IDXW-1:0]     rec_idx_q;
  logic [63:0]         sample_q;
  logic [6:0]          in_idx;
  logic [63:0]         dec;

  logic                div_go, div_done;
  logic [DIV_DW-1:0]   div_dvd;
  logic [DIV_VW-1:0]   div_dvs;
  logic [DIV_VW-1:0]   div_quo;
  logic [RANK_W-1:0]   tgt_q [3];
  logic [63:0]         mean_q;

  logic [IDXW-1:0]     walk_q;
  logic [63:0]         cum_q, cum_nx;
  logic [RANK_W-1:0]   cum_x100;
  logic [2:0]          found_q;
  logic [63:0]         bnd_q [3];

  logic                done_q;
  lhist_result_t       res_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Bucket of the incoming sample: bit width of sample - 1, capped
  always_comb begin
    logic [6:0] w;
    w   = '0;
    dec = item_i.sample_ns - 64'd1;
    for (int k = 0; k < 64; k++) begin
      if (dec[k]) begin
        w = 7'(k + 1);
      end
    end
    if (item_i.sample_ns <= 64'd1) begin
      w = '0;
    end
    in_idx = (w > LAST_B) ? LAST_B : w;
  end

  // Next state, read address and divider launch
  always_comb begin
    state_d = state_q;
    rd_addr = '0;
    div_go  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rd_addr = in_idx[IDXW-1:0];
        if (accept && item_i.mode == MODE_RECORD) begin
          state_d = ST_REC;
        end else if (accept && item_i.mode == MODE_SNAPSHOT && total_q != '0) begin
          state_d = ST_DIV_GO;
        end
      end
      ST_REC:      state_d = ST_IDLE;
      ST_DIV_GO: begin
        div_go  = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_PRE_WALK;
        end
      end
      ST_PRE_WALK: state_d = ST_WALK;
      ST_WALK: begin
        rd_addr = (walk_q == LAST_I) ? '0 : walk_q + IDXW'(1);
        if (walk_q == LAST_I) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Mean job for the divider
  assign div_dvd = DIV_DW'(sum_q);
  assign div_dvs = total_q;

  lhist_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Bucket memory: one read port, one write port
  assign bucket_val = rd_vld_q ? rd_data_q : '0;
  assign mem_we     = (state_q == ST_REC);
  assign mem_wdata  = (bucket_val == '1) ? bucket_val : bucket_val + 64'd1;

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
    if (mem_we) begin
      mem_q[rec_idx_q] <= mem_wdata;
    end
  end

  // Running count, scaled by 100 for the rank compare
  assign cum_nx   = sat_add64(cum_q, bucket_val);
  assign cum_x100 = RANK_W'(cum_nx) * RANK_W'(PCT_SCALE);

  // Control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= '0;
      total_q <= '0;
      sum_q   <= '0;
      peak_q  <= '0;
      walk_q  <= '0;
      found_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (accept) begin
        case (item_i.mode)
          MODE_RECORD: begin
            if (item_i.sample_ns > peak_q) begin
              peak_q <= item_i.sample_ns;
            end
          end
          MODE_SNAPSHOT: begin
            if (total_q == '0) begin
              done_q <= 1'b1;
            end
          end
          MODE_CLEAR: begin
            vld_q   <= '0;
            total_q <= '0;
            sum_q   <= '0;
            peak_q  <= '0;
          end
          default: ;
        endcase
      end
      if (mem_we) begin
        vld_q[rec_idx_q] <= 1'b1;
        if (total_q != '1) begin
          total_q <= total_q + 64'd1;
        end
        sum_q <= sat_add64(sum_q, sample_q);
      end
      if (state_q == ST_PRE_WALK) begin
        walk_q  <= '0;
        found_q <= '0;
      end
      if (state_q == ST_WALK) begin
        walk_q <= walk_q + IDXW'(1);
        for (int j = 0; j < 3; j++) begin
          if (!found_q[j] && cum_x100 >= tgt_q[j]) begin
            found_q[j] <= 1'b1;
          end
        end
      end
      if (state_q == ST_DONE) begin
        done_q <= 1'b1;
      end
    end
  end

  // Item payload, rank targets, walk sums and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rec_idx_q <= in_idx[IDXW-1:0];
      sample_q  <= item_i.sample_ns;
      if (item_i.mode == MODE_SNAPSHOT) begin
        res_q <= '0;
      end
    end
    if (state_q == ST_DIV_WAIT && div_done) begin
      mean_q <= div_quo;
    end
    if (state_q == ST_PRE_WALK) begin
      cum_q    <= '0;
      tgt_q[0] <= RANK_W'(total_q) * RANK_W'(PCT_MEDIAN);
      tgt_q[1] <= RANK_W'(total_q) * RANK_W'(PCT_P95);
      tgt_q[2] <= RANK_W'(total_q) * RANK_W'(PCT_P99);
    end
    if (state_q == ST_WALK) begin
      cum_q <= cum_nx;
      for (int j = 0; j < 3; j++) begin
        if (!found_q[j] && cum_x100 >= tgt_q[j]) begin
          bnd_q[j] <= bound_of(7'(walk_q), LAST_B);
        end
      end
    end
    if (state_q == ST_DONE) begin
      res_q.count_out    <= total_q;
      res_q.median_bound <= found_q[0] ? bnd_q[0] : '1;
      res_q.p95_bound    <= found_q[1] ? bnd_q[1] : '1;
      res_q.p99_bound    <= found_q[2] ? bnd_q[2] : '1;
      res_q.largest_ns   <= peak_q;
      res_q.mean_ns      <= mean_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // The walk never runs past the last bucket
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (walk_q <= LAST_I))
    else $error("walk index past last bucket");

  // The divider only finishes while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_WAIT))
    else $error("divider finished outside wait state");

  // A result with no samples carries all zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.count_out == '0) |->
      (result_o.mean_ns == '0 && result_o.largest_ns == '0 && result_o.median_bound == '0))
    else $error("empty snapshot not zero");

  // A bucket write follows the idle cycle that took the record
  a_rec_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REC) |-> $past(state_q == ST_IDLE))
    else $error("record write without accepted item");

endmodule

FILE: tb/lhist_checker.sv
// Checker for the log2 latency histogram: predicts snapshot results and compares them.
module lhist_checker
  import lhist_pkg::*;
#(
  parameter int unsigned BUCKETS = DEF_BUCKETS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  lhist_item_t   item_i,
  input  logic          done_i,
  input  lhist_result_t result_i,
  output int            errors_o,
  output int            pending_o
);

  localparam logic [63:0] ALL_ONES = '1;

  // Shadow copy of the histogram statistics
  logic [63:0] hist_bins [BUCKETS];
  logic [63:0] hist_count;
  logic [63:0] hist_sum;
  logic [63:0] hist_peak;

  lhist_result_t snapshot_q[$];
  int            mismatches;

  assign errors_o  = mismatches;
  assign pending_o = snapshot_q.size();

  function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  // Log2 bin of a sample: bit width of sample-1, capped at the last bin
  function automatic int bin_index(logic [63:0] s);
    logic [63:0] v;
    int w;
    w = 0;
    if (s <= 64'd1) return 0;
    v = s - 64'd1;
    while (v != 0) begin
      w++;
      v = v >> 1;
    end
    return (w > BUCKETS - 1) ? BUCKETS - 1 : w;
  endfunction

  function automatic logic [63:0] bin_limit(int idx);
    if (idx >= BUCKETS - 1 || idx > 63) return ALL_ONES;
    return 64'd1 << idx;
  endfunction

  // Ceiling-rank cumulative walk over the bins
  function automatic logic [63:0] percentile_limit(logic [63:0] p);
    logic [63:0] rank;
    logic [63:0] cum;
    rank = (hist_count / 100) * p + ((hist_count % 100) * p + 64'd99) / 100;
    cum = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      cum = clamp_add(cum, hist_bins[i]);
      if (cum >= rank) return bin_limit(i);
    end
    return ALL_ONES;
  endfunction

  task automatic wipe_stats();
    for (int i = 0; i < BUCKETS; i++) hist_bins[i] = '0;
    hist_count = '0;
    hist_sum   = '0;
    hist_peak  = '0;
  endtask

  task automatic apply_item(lhist_item_t it);
    lhist_result_t r;
    int b;
    case (it.mode)
      MODE_RECORD: begin
        b = bin_index(it.sample_ns);
        if (hist_bins[b] != ALL_ONES) hist_bins[b]++;
        if (hist_count != ALL_ONES) hist_count++;
        hist_sum = clamp_add(hist_sum, it.sample_ns);
        if (it.sample_ns > hist_peak) hist_peak = it.sample_ns;
      end
      MODE_SNAPSHOT: begin
        r = '0;
        if (hist_count != 0) begin
          r.count_out    = hist_count;
          r.median_bound = percentile_limit(64'(PCT_MEDIAN));
          r.p95_bound    = percentile_limit(64'(PCT_P95));
          r.p99_bound    = percentile_limit(64'(PCT_P99));
          r.largest_ns   = hist_peak;
          r.mean_ns      = hist_sum / hist_count;
        end
        snapshot_q.push_back(r);
      end
      MODE_CLEAR: wipe_stats();
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    wipe_stats();
  end

  // Compare results first, then fold in the item taken at this edge
  always @(posedge clk_i) begin
    lhist_result_t e;
    if (rst_ni) begin
      if (done_i) begin
        if (snapshot_q.size() == 0) begin
          $error("result with no snapshot pending");
          mismatches++;
        end else begin
          e = snapshot_q.pop_front();
          check_field("count_out", e.count_out, result_i.count_out);
          check_field("median_bound", e.median_bound, result_i.median_bound);
          check_field("p95_bound", e.p95_bound, result_i.p95_bound);
          check_field("p99_bound", e.p99_bound, result_i.p99_bound);
          check_field("largest_ns", e.largest_ns, result_i.largest_ns);
          check_field("mean_ns", e.mean_ns, result_i.mean_ns);
        end
      end
      if (start_i && !busy_i) apply_item(item_i);
    end
  end

endmodule

FILE: tb/tb_log2_latency_histogram_core.sv
// Testbench top for the log2 latency histogram: stimulus, watchdog and verdict.
module tb_log2_latency_histogram_core;
  import lhist_pkg::*;

  localparam int RANDOM_ITEMS = 1530;
  localparam int CALM_TAIL    = 200;
  localparam int STALL_LIMIT  = 3000;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  lhist_item_t   item_i;
  logic          done_o;
  lhist_result_t result_o;
  int            errors;
  int            pending;
  int            quiet_cycles;

  log2_latency_histogram_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  lhist_checker chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_i   (busy),
    .item_i   (item_i),
    .done_i   (done_o),
    .result_i (result_o),
    .errors_o (errors),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the item until the block takes it
  task automatic send_item(logic [1:0] mode, logic [63:0] sample, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    item_i.mode    <= mode;
    item_i.sample_ns <= sample;
    do @(posedge clk_i); while (busy);
  endtask

  // Sample with a random bit width so every bin gets traffic
  function automatic logic [63:0] pick_sample();
    logic [63:0] v;
    int w;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return v;
    w = $urandom_range(0, 40);
    return (w == 0) ? 64'd0 : (v & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - w)));
  endfunction

  initial begin
    int sel;
    bit gaps;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty snapshot, ignored mode, field extremes, clear
    send_item(MODE_SNAPSHOT, '0, 1'b0);
    send_item(MODE_UNUSED, '1, 1'b0);
    send_item(MODE_SNAPSHOT, '0, 1'b0);
    send_item(MODE_RECORD, 64'd0, 1'b0);
    send_item(MODE_RECORD, 64'd1, 1'b0);
    send_item(MODE_RECORD, 64'd2, 1'b0);
    send_item(MODE_RECORD, 64'd3, 1'b0);
    send_item(MODE_SNAPSHOT, '0, 1'b0);
    send_item(MODE_RECORD, 64'h4000_0000, 1'b0);
    send_item(MODE_RECORD, 64'h4000_0001, 1'b0);
    send_item(MODE_RECORD, 64'h8000_0000_0000_0000, 1'b0);
    send_item(MODE_SNAPSHOT, '0, 1'b0);
    send_item(MODE_RECORD, '1, 1'b0);
    send_item(MODE_RECORD, '1, 1'b0);
    send_item(MODE_SNAPSHOT, '0, 1'b0);
    send_item(MODE_CLEAR, '1, 1'b0);
    send_item(MODE_SNAPSHOT, '0, 1'b0);
    send_item(MODE_RECORD, 64'h5555_5555_5555_5555, 1'b0);
    send_item(MODE_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_item(MODE_SNAPSHOT, '0, 1'b0);
    send_item(MODE_CLEAR, '0, 1'b0);

    // Random: mostly records, some snapshots, rare clears and unused mode
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 100) % 3 != 2);
      sel = $urandom_range(0, 99);
      if (sel < 88) send_item(MODE_RECORD, pick_sample(), gaps);
      else if (sel < 96) send_item(MODE_SNAPSHOT, pick_sample(), gaps);
      else if (sel < 98) send_item(MODE_CLEAR, pick_sample(), gaps);
      else send_item(MODE_UNUSED, pick_sample(), gaps);
    end
    send_item(MODE_SNAPSHOT, '0, 1'b0);
    start <= 1'b0;

    // Drain outstanding snapshots, then let the block settle
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
